FILE: rtl/one_wire_bus_master_top_defines.svh
// ----------------------------------------------------------------------------
// one-wire bus master assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OWBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("owbm assertion failed");

// next-cycle implication, disabled during reset
`define OWBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("owbm assertion failed");

`endif

FILE: rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// shared types and constants of the one-wire bus master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owbm_pkg;

	localparam int TIMER_BITS_DEF = 10;
	localparam int CFG_W          = 10;
	localparam int CFG_IDX_W      = 3;
	localparam int IN_DATA_W      = 16;
	localparam int IN_USER_W      = 3;
	localparam int OUT_DATA_W     = 16;

	// command codes
	localparam logic [2:0] OP_NONE       = 3'd0;
	localparam logic [2:0] OP_RESET      = 3'd1;
	localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
	localparam logic [2:0] OP_READ_BYTE  = 3'd3;
	localparam logic [2:0] OP_WRITE_BIT  = 3'd4;
	localparam logic [2:0] OP_READ_BIT   = 3'd5;

	// reset status codes
	localparam logic [1:0] ST_PRESENCE = 2'd0;
	localparam logic [1:0] ST_HELD_LOW = 2'd1;
	localparam logic [1:0] ST_NO_PRES  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_SLOT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_SLOT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_READ_HOLD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AFTER_RESET = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0] RST_RESET_LOW   = 10'd480;
	localparam logic [CFG_W-1:0] RST_LONG_SLOT   = 10'd60;
	localparam logic [CFG_W-1:0] RST_SHORT_SLOT  = 10'd10;
	localparam logic [CFG_W-1:0] RST_READ_HOLD   = 10'd2;
	localparam logic [CFG_W-1:0] RST_AFTER_RESET = 10'd420;

	localparam int BITS_PER_BYTE = 8;

	typedef struct packed {
		logic [CFG_W-1:0] reset_low_time;
		logic [CFG_W-1:0] long_slot_time;
		logic [CFG_W-1:0] short_slot_time;
		logic [CFG_W-1:0] read_hold_time;
		logic [CFG_W-1:0] after_reset_time;
	} cfg_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
		logic       pull_low;
	} res_t;

endpackage

FILE: rtl/one_wire_bus_master_top.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_top: a tick's result is registered at its accept
// throughput one tick per cycle while no held result is stalled, set by the single-step sequencer state update
// the output register frees s_tready whenever m_tready takes the held result
// arst_n clears all state but the result register: idle, timers zero, registers to default times
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_wire_bus_master_top #(
	parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// data_byte[7:0], line_level[8], zero fill
	input  logic [owbm_pkg::IN_DATA_W-1:0]    s_tdata,
	// opcode[2:0]
	input  logic [owbm_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pull_low[0], busy_res[1], done_res[2], read_data[10:3], status[12:11], zero fill
	output logic [owbm_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [owbm_pkg::CFG_W-1:0]        cfg_data
);

	owbm_pkg::cfg_t cfg;
	owbm_pkg::res_t res;
	logic           accept;
	logic           m_tvalid_q;
	owbm_pkg::res_t m_res_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	owbm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	owbm_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.opcode     (s_tuser),
		.data_byte  (s_tdata[7:0]),
		.line_level (s_tdata[8]),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(owbm_pkg::OUT_DATA_W - $bits(owbm_pkg::res_t)){1'b0}}, m_res_q};

endmodule

FILE: rtl/owbm_cfg.sv
// ----------------------------------------------------------------------------
// owbm_cfg
// timing register file, written over the configuration channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owbm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [owbm_pkg::CFG_W-1:0]       wr_data,
	output owbm_pkg::cfg_t                   cfg
);

	owbm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time   <= owbm_pkg::RST_RESET_LOW;
			cfg_q.long_slot_time   <= owbm_pkg::RST_LONG_SLOT;
			cfg_q.short_slot_time  <= owbm_pkg::RST_SHORT_SLOT;
			cfg_q.read_hold_time   <= owbm_pkg::RST_READ_HOLD;
			cfg_q.after_reset_time <= owbm_pkg::RST_AFTER_RESET;
		end else if (wr_en) begin
			case (wr_index)
				owbm_pkg::REG_RESET_LOW:   cfg_q.reset_low_time   <= wr_data;
				owbm_pkg::REG_LONG_SLOT:   cfg_q.long_slot_time   <= wr_data;
				owbm_pkg::REG_SHORT_SLOT:  cfg_q.short_slot_time  <= wr_data;
				owbm_pkg::REG_READ_HOLD:   cfg_q.read_hold_time   <= wr_data;
				owbm_pkg::REG_AFTER_RESET: cfg_q.after_reset_time <= wr_data;
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/owbm_core.sv
// ----------------------------------------------------------------------------
// owbm_core
// bus timing sequencer, advances one phase step per accepted tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owbm_core #(
	parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [2:0]     opcode,
	input  logic [7:0]     data_byte,
	input  logic           line_level,
	input  owbm_pkg::cfg_t cfg,
	output owbm_pkg::res_t res
);

	typedef enum logic [9:0] {
		PH_IDLE      = 10'b00_0000_0001,
		PH_RST_LOW   = 10'b00_0000_0010,
		PH_RST_WAIT  = 10'b00_0000_0100,
		PH_RST_AFTER = 10'b00_0000_1000,
		PH_WR_LOW    = 10'b00_0001_0000,
		PH_WR_HIGH   = 10'b00_0010_0000,
		PH_RD_LOW    = 10'b00_0100_0000,
		PH_RD_WAIT   = 10'b00_1000_0000,
		PH_RD_TAIL   = 10'b01_0000_0000,
		PH_BYTE_TAIL = 10'b10_0000_0000
	} phase_t;

	localparam int CW = owbm_pkg::CFG_W;

	phase_t                phase_q;
	logic [TIMER_BITS-1:0] time_left_q;
	logic [3:0]            bit_index_q;
	logic [7:0]            shift_data_q;
	logic [2:0]            active_cmd_q;
	logic [1:0]            last_status_q;
	logic [7:0]            held_read_q;

	phase_t                ph_n;
	logic [TIMER_BITS-1:0] tl_n;
	logic [3:0]            bi_n;
	logic [7:0]            sd_n;
	logic [2:0]            act_n;
	logic [1:0]            st_n;
	logic [7:0]            hr_n;
	logic                  pull;
	logic                  done;

	// clamp a register time to the timer range
	function automatic logic [TIMER_BITS-1:0] sat(input logic [CW-1:0] t);
		logic [CW+TIMER_BITS-1:0] tw;
		logic [CW+TIMER_BITS-1:0] cw;
		tw = {{TIMER_BITS{1'b0}}, t};
		cw = {{CW{1'b0}}, {TIMER_BITS{1'b1}}};
		if (tw > cw)
			sat = {TIMER_BITS{1'b1}};
		else
			sat = tw[TIMER_BITS-1:0];
	endfunction

	always_comb begin
		ph_n  = phase_q;
		tl_n  = time_left_q;
		bi_n  = bit_index_q;
		sd_n  = shift_data_q;
		act_n = active_cmd_q;
		st_n  = last_status_q;
		hr_n  = held_read_q;
		pull  = 1'b0;
		done  = 1'b0;

		// command start, the first phase runs on this same tick
		if (phase_q == PH_IDLE && opcode >= owbm_pkg::OP_RESET &&
				opcode <= owbm_pkg::OP_READ_BIT) begin
			act_n = opcode;
			bi_n  = 4'd0;
			case (opcode)
				owbm_pkg::OP_RESET: begin
					if (!line_level) begin
						st_n = owbm_pkg::ST_HELD_LOW;
						done = 1'b1;
					end else begin
						ph_n = PH_RST_LOW;
						tl_n = sat(cfg.reset_low_time);
					end
				end
				owbm_pkg::OP_WRITE_BYTE, owbm_pkg::OP_WRITE_BIT: begin
					sd_n = (opcode == owbm_pkg::OP_WRITE_BYTE) ? data_byte :
						{7'd0, data_byte[0]};
					ph_n = PH_WR_LOW;
					tl_n = sat(sd_n[0] ? cfg.short_slot_time : cfg.long_slot_time);
				end
				default: begin
					sd_n = 8'd0;
					ph_n = PH_RD_LOW;
					tl_n = sat(cfg.read_hold_time);
				end
			endcase
		end

		if (ph_n != PH_IDLE) begin
			pull = (ph_n == PH_RST_LOW) || (ph_n == PH_WR_LOW) || (ph_n == PH_RD_LOW);
			if (tl_n > TIMER_BITS'(1)) begin
				tl_n = tl_n - TIMER_BITS'(1);
			end else begin
				case (ph_n)
					PH_RST_LOW: begin
						ph_n = PH_RST_WAIT;
						tl_n = sat(cfg.long_slot_time);
					end
					PH_RST_WAIT: begin
						st_n = line_level ? owbm_pkg::ST_NO_PRES : owbm_pkg::ST_PRESENCE;
						if (cfg.after_reset_time == '0) begin
							ph_n = PH_IDLE;
							tl_n = '0;
							done = 1'b1;
						end else begin
							ph_n = PH_RST_AFTER;
							tl_n = sat(cfg.after_reset_time);
						end
					end
					PH_WR_LOW: begin
						ph_n = PH_WR_HIGH;
						tl_n = sat(sd_n[0] ? cfg.long_slot_time : cfg.short_slot_time);
					end
					PH_WR_HIGH: begin
						bi_n = bi_n + 4'd1;
						sd_n = {1'b0, sd_n[7:1]};
						if (act_n == owbm_pkg::OP_WRITE_BYTE &&
								bi_n < 4'(owbm_pkg::BITS_PER_BYTE)) begin
							ph_n = PH_WR_LOW;
							tl_n = sat(sd_n[0] ? cfg.short_slot_time : cfg.long_slot_time);
						end else begin
							ph_n = PH_IDLE;
							tl_n = '0;
							done = 1'b1;
						end
					end
					PH_RD_LOW: begin
						ph_n = PH_RD_WAIT;
						tl_n = sat(cfg.short_slot_time);
					end
					PH_RD_WAIT: begin
						if (line_level)
							sd_n[bi_n[2:0]] = 1'b1;
						ph_n = PH_RD_TAIL;
						tl_n = sat(cfg.long_slot_time);
					end
					PH_RD_TAIL: begin
						bi_n = bi_n + 4'd1;
						if (act_n == owbm_pkg::OP_READ_BYTE) begin
							if (bi_n < 4'(owbm_pkg::BITS_PER_BYTE)) begin
								ph_n = PH_RD_LOW;
								tl_n = sat(cfg.read_hold_time);
							end else begin
								ph_n = PH_BYTE_TAIL;
								tl_n = sat(cfg.long_slot_time);
							end
						end else begin
							hr_n = sd_n;
							ph_n = PH_IDLE;
							tl_n = '0;
							done = 1'b1;
						end
					end
					PH_BYTE_TAIL: begin
						hr_n = sd_n;
						ph_n = PH_IDLE;
						tl_n = '0;
						done = 1'b1;
					end
					default: begin
						// recovery wait and any stray code simply finish
						ph_n = PH_IDLE;
						tl_n = '0;
						done = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			time_left_q   <= '0;
			bit_index_q   <= 4'd0;
			shift_data_q  <= 8'd0;
			active_cmd_q  <= owbm_pkg::OP_NONE;
			last_status_q <= owbm_pkg::ST_PRESENCE;
			held_read_q   <= 8'd0;
		end else if (step) begin
			phase_q       <= ph_n;
			time_left_q   <= tl_n;
			bit_index_q   <= bi_n;
			shift_data_q  <= sd_n;
			active_cmd_q  <= act_n;
			last_status_q <= st_n;
			held_read_q   <= hr_n;
		end
	end

	always_comb begin
		res.pull_low  = pull;
		res.busy_res  = (ph_n != PH_IDLE);
		res.done_res  = done;
		res.read_data = hr_n;
		res.status    = st_n;
	end

endmodule

FILE: rtl/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker
// port-level checks of the one-wire bus master, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "one_wire_bus_master_top_defines.svh"

module owbm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [owbm_pkg::OUT_DATA_W-1:0] m_tdata
);

	// a stalled result keeps its transaction pending
	`OWBM_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// no new tick is taken while the held result is stalled
	`OWBM_ASSERT_IMP(a_in_block, clk, arst_n, m_tvalid && !m_tready, !s_tready)

	// a completing command leaves the master idle
	`OWBM_ASSERT_IMP(a_done_idle, clk, arst_n, m_tvalid && m_tdata[2], !m_tdata[1])

	// the line is only driven while a command runs
	`OWBM_ASSERT_IMP(a_pull_busy, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[1])

	// status code three is never reported
	`OWBM_ASSERT_IMP(a_status_code, clk, arst_n, m_tvalid, m_tdata[12:11] != 2'd3)

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
